@@ sv/gradient_optimizer_update_macros.svh @@
// Assertion macros for the gradient optimizer update block.
// Clocked on aclk, disabled while aresetn is low; no other dependencies.
`ifndef GRADIENT_OPTIMIZER_UPDATE_MACROS_SVH
`define GRADIENT_OPTIMIZER_UPDATE_MACROS_SVH

// same-cycle implication
`define GOU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GOU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/gou_pkg.sv @@
// Shared types, constants and helpers of the gradient optimizer update block.
// No dependencies.
`default_nettype none

package gou_pkg;

    localparam int CACHE_DEPTH = 4096;
    localparam int CACHE_AW    = $clog2(CACHE_DEPTH);
    localparam int QDEPTH      = 4;
    localparam int QAW         = $clog2(QDEPTH);

    localparam int ISQRT_STEPS = 25;
    localparam int DIV_STEPS   = 48;

    localparam logic [1:0] MODE_SGD  = 2'd0;
    localparam logic [1:0] MODE_MOM  = 2'd1;
    localparam logic [1:0] MODE_RMS  = 2'd2;
    localparam logic [1:0] MODE_RSVD = 2'd3;   // unused, runs as plain SGD

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_END    = 1'b1;

    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_RATE  = 3'd1;
    localparam logic [2:0] REG_MOM   = 3'd2;
    localparam logic [2:0] REG_SQD   = 3'd3;
    localparam logic [2:0] REG_RDEC  = 3'd4;
    localparam logic [2:0] REG_RDEN  = 3'd5;

    localparam logic [15:0] RATE_RESET = 16'd655;
    localparam logic [15:0] COEF_RESET = 16'd58982;
    localparam logic [15:0] RDEC_RESET = 16'd65535;

    typedef enum logic [1:0] {
        K_END,
        K_SGD,
        K_MOM,
        K_RMS
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [11:0]        idx;
        logic signed [31:0] p;
        logic signed [31:0] g;
    } qent_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] init_rate;
        logic [15:0] mom_coef;
        logic [15:0] sq_decay;
        logic [15:0] rate_decay;
        logic        decay_en;
    } cfg_t;

    typedef struct packed {
        logic clearing;
    } bstat_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOM_MUL,
        ST_MOM_ADD,
        ST_STEP_MUL,
        ST_STEP_FIN,
        ST_RMS_SQ,
        ST_RMS_A,
        ST_RMS_B,
        ST_RMS_SUM,
        ST_RMS_NUM,
        ST_SQRT,
        ST_DIV,
        ST_RMS_FIN,
        ST_OUT
    } state_t;

    // cache slot of an element index (depth is a power of two)
    function automatic logic [CACHE_AW-1:0] slot_of(input logic [11:0] idx);
        logic [31:0] w;
        w = 32'(idx);
        return w[CACHE_AW-1:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = 50'sh7FFF_FFFF;
        lo = -50'sh8000_0000;
        if (x > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (x < lo) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/gou_front.sv @@
// Front end: accepts input words, classifies them and queues them.
// Depends on gou_pkg.
`default_nettype none

module gou_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_operation,
    input  wire logic [11:0]         s_element_index,
    input  wire logic signed [31:0]  s_weight,
    input  wire logic signed [31:0]  s_gradient,
    input  wire logic [1:0]          mode,
    input  wire gou_pkg::bstat_t     bstat,
    output logic                     q_valid,
    output gou_pkg::qent_t           q_ent,
    input  wire logic                q_pop
);

    gou_pkg::qent_t       qmem_reg [gou_pkg::QDEPTH];
    logic [gou_pkg::QAW-1:0] wptr_reg, rptr_reg;
    logic [gou_pkg::QAW:0]   cnt_reg, cnt_next;
    gou_pkg::kind_t       kind;
    logic                 push;

    always_comb begin
        if (s_operation == gou_pkg::OP_END) begin
            kind = gou_pkg::K_END;
        end else if (mode == gou_pkg::MODE_MOM) begin
            kind = gou_pkg::K_MOM;
        end else if (mode == gou_pkg::MODE_RMS) begin
            kind = gou_pkg::K_RMS;
        end else begin
            kind = gou_pkg::K_SGD;
        end
    end

    assign s_ready = (cnt_reg != (gou_pkg::QAW+1)'(gou_pkg::QDEPTH)) && !bstat.clearing;
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign q_ent   = qmem_reg[rptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !q_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && q_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (q_pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            qmem_reg[wptr_reg] <= '{kind: kind, idx: s_element_index,
                                    p: s_weight, g: s_gradient};
        end
    end

endmodule

`default_nettype wire

@@ sv/gou_back.sv @@
// Back end: per-element update sequencer with the step cache, isqrt and divider.
// Depends on gou_pkg and gradient_optimizer_update_macros.svh.
`default_nettype none
`include "gradient_optimizer_update_macros.svh"

module gou_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire gou_pkg::cfg_t       cfg,
    input  wire logic                rate_load,
    input  wire logic                q_valid,
    input  wire gou_pkg::qent_t      q_ent,
    output logic                     q_pop,
    output gou_pkg::bstat_t          bstat,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [11:0]              m_result_index,
    output logic signed [31:0]       m_new_weight
);

    gou_pkg::state_t state_reg, state_next;

    logic [31:0] cache_mem [gou_pkg::CACHE_DEPTH];
    logic [31:0] rd_reg;
    logic [gou_pkg::CACHE_AW-1:0] clr_reg, slot_reg, waddr;
    logic        mem_we, mem_re, out_load;
    logic [31:0] wdata;

    logic [11:0]        idx_reg;
    logic signed [31:0] p_reg, g_reg, x_reg, np_reg;
    logic signed [48:0] prod_reg;
    logic [15:0]        rate_reg;
    logic [31:0]        sq_reg;
    logic [47:0]        a_reg;
    logic [48:0]        b_reg;
    logic [49:0]        sx_reg, r_reg, bit_reg;
    logic [5:0]         cnt_reg;
    logic [24:0]        rem_reg;
    logic [47:0]        dvd_reg;
    logic               neg_reg;
    logic               m_valid_reg;

    // combinational datapath values
    logic signed [33:0] vsum;
    logic signed [31:0] v_new;
    logic [31:0]        ug;
    logic [63:0]        sq64;
    logic [33:0]        ssum;
    logic [31:0]        s_new;
    logic [49:0]        sq_t;
    logic [25:0]        remsh;
    logic [24:0]        root;
    logic [31:0]        rdec_prod;

    assign vsum  = 34'(prod_reg >>> 16) + 34'(g_reg);
    assign v_new = gou_pkg::sat32(50'(vsum));
    assign ug    = g_reg[31] ? (~g_reg + 32'd1) : g_reg;
    assign sq64  = ug * ug;
    assign ssum  = 34'(a_reg[47:16]) + 34'(b_reg[48:16]);
    assign s_new = (ssum[33:32] != 2'b00) ? 32'hFFFF_FFFF : ssum[31:0];
    assign sq_t  = r_reg + bit_reg;
    assign root  = r_reg[24:0];
    assign remsh = {rem_reg, dvd_reg[47]};
    assign rdec_prod = rate_reg * cfg.rate_decay;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gou_pkg::ST_CLEAR: begin
                if (clr_reg == '1) state_next = gou_pkg::ST_IDLE;
            end
            gou_pkg::ST_IDLE: begin
                if (q_valid) begin
                    unique case (q_ent.kind)
                        gou_pkg::K_END: state_next = gou_pkg::ST_IDLE;
                        gou_pkg::K_SGD: state_next = gou_pkg::ST_STEP_MUL;
                        gou_pkg::K_MOM: state_next = gou_pkg::ST_MOM_MUL;
                        gou_pkg::K_RMS: state_next = gou_pkg::ST_RMS_SQ;
                    endcase
                end
            end
            gou_pkg::ST_MOM_MUL:  state_next = gou_pkg::ST_MOM_ADD;
            gou_pkg::ST_MOM_ADD:  state_next = gou_pkg::ST_STEP_MUL;
            gou_pkg::ST_STEP_MUL: state_next = gou_pkg::ST_STEP_FIN;
            gou_pkg::ST_STEP_FIN: state_next = gou_pkg::ST_OUT;
            gou_pkg::ST_RMS_SQ:   state_next = gou_pkg::ST_RMS_A;
            gou_pkg::ST_RMS_A:    state_next = gou_pkg::ST_RMS_B;
            gou_pkg::ST_RMS_B:    state_next = gou_pkg::ST_RMS_SUM;
            gou_pkg::ST_RMS_SUM:  state_next = gou_pkg::ST_RMS_NUM;
            gou_pkg::ST_RMS_NUM:  state_next = gou_pkg::ST_SQRT;
            gou_pkg::ST_SQRT: begin
                if (cnt_reg == 6'(gou_pkg::ISQRT_STEPS - 1)) state_next = gou_pkg::ST_DIV;
            end
            gou_pkg::ST_DIV: begin
                if (cnt_reg == 6'(gou_pkg::DIV_STEPS - 1)) state_next = gou_pkg::ST_RMS_FIN;
            end
            gou_pkg::ST_RMS_FIN:  state_next = gou_pkg::ST_OUT;
            gou_pkg::ST_OUT: begin
                if (out_load) state_next = gou_pkg::ST_IDLE;
            end
            default: state_next = gou_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        q_pop    = 1'b0;
        mem_re   = 1'b0;
        mem_we   = 1'b0;
        waddr    = slot_reg;
        wdata    = '0;
        out_load = 1'b0;
        bstat.clearing = 1'b0;
        unique case (state_reg)
            gou_pkg::ST_CLEAR: begin
                bstat.clearing = 1'b1;
                mem_we = 1'b1;
                waddr  = clr_reg;
            end
            gou_pkg::ST_IDLE: begin
                q_pop  = q_valid;
                mem_re = q_valid;
            end
            gou_pkg::ST_MOM_ADD: begin
                mem_we = 1'b1;
                wdata  = v_new;
            end
            gou_pkg::ST_RMS_SUM: begin
                mem_we = 1'b1;
                wdata  = s_new;
            end
            gou_pkg::ST_OUT: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cache_mem[waddr] <= wdata;
        end
        if (mem_re) begin
            rd_reg <= cache_mem[gou_pkg::slot_of(q_ent.idx)];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gou_pkg::ST_CLEAR;
            clr_reg     <= '0;
            rate_reg    <= gou_pkg::RATE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == gou_pkg::ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (rate_load) begin
                rate_reg <= cfg.init_rate;
            end else if (q_pop && q_ent.kind == gou_pkg::K_END && cfg.decay_en) begin
                rate_reg <= rdec_prod[31:16];
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            gou_pkg::ST_IDLE: begin
                idx_reg  <= q_ent.idx;
                slot_reg <= gou_pkg::slot_of(q_ent.idx);
                p_reg    <= q_ent.p;
                g_reg    <= q_ent.g;
                x_reg    <= q_ent.g;
            end
            gou_pkg::ST_MOM_MUL: begin
                prod_reg <= $signed({1'b0, cfg.mom_coef}) * $signed(rd_reg);
            end
            gou_pkg::ST_MOM_ADD: begin
                x_reg <= v_new;
            end
            gou_pkg::ST_STEP_MUL: begin
                prod_reg <= $signed({1'b0, rate_reg}) * x_reg;
            end
            gou_pkg::ST_STEP_FIN: begin
                np_reg <= gou_pkg::sat32(50'(p_reg) - 50'(prod_reg >>> 16));
            end
            gou_pkg::ST_RMS_SQ: begin
                sq_reg <= (sq64[63:48] != 16'd0) ? 32'hFFFF_FFFF : sq64[47:16];
            end
            gou_pkg::ST_RMS_A: begin
                a_reg <= cfg.sq_decay * rd_reg;
            end
            gou_pkg::ST_RMS_B: begin
                b_reg <= (17'h1_0000 - {1'b0, cfg.sq_decay}) * sq_reg;
            end
            gou_pkg::ST_RMS_SUM: begin
                sx_reg  <= 50'({1'b0, s_new} + 33'd1) << 16;
                r_reg   <= '0;
                bit_reg <= 50'(1) << 48;
                cnt_reg <= '0;
            end
            gou_pkg::ST_RMS_NUM: begin
                prod_reg <= $signed({1'b0, rate_reg}) * g_reg;
            end
            gou_pkg::ST_SQRT: begin
                if (sx_reg >= sq_t) begin
                    sx_reg <= sx_reg - sq_t;
                    r_reg  <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg  <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (cnt_reg == 6'(gou_pkg::ISQRT_STEPS - 1)) begin
                    cnt_reg <= '0;
                    rem_reg <= '0;
                    neg_reg <= prod_reg[48];
                    dvd_reg <= prod_reg[48] ? 48'(-prod_reg) : prod_reg[47:0];
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            gou_pkg::ST_DIV: begin
                // restoring division, one quotient bit per cycle
                if (remsh >= {1'b0, root}) begin
                    rem_reg <= 25'(remsh - {1'b0, root});
                    dvd_reg <= {dvd_reg[46:0], 1'b1};
                end else begin
                    rem_reg <= remsh[24:0];
                    dvd_reg <= {dvd_reg[46:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            gou_pkg::ST_RMS_FIN: begin
                np_reg <= gou_pkg::sat32(neg_reg ? 50'(p_reg) + 50'({2'b00, dvd_reg})
                                                 : 50'(p_reg) - 50'({2'b00, dvd_reg}));
            end
            gou_pkg::ST_OUT: begin
                if (out_load) begin
                    m_result_index <= idx_reg;
                    m_new_weight   <= np_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;

    `GOU_ASSERT_NOW(a_pop_idle, q_pop, state_reg == gou_pkg::ST_IDLE && q_valid, "pop outside idle")
    `GOU_ASSERT_NOW(a_we_state, mem_we && state_reg != gou_pkg::ST_CLEAR, state_reg == gou_pkg::ST_MOM_ADD || state_reg == gou_pkg::ST_RMS_SUM, "stray cache write")
    `GOU_ASSERT_NOW(a_root_min, state_reg == gou_pkg::ST_DIV, root >= 25'd256, "root below epsilon floor")
    `GOU_ASSERT_NEXT(a_out_idle, out_load, state_reg == gou_pkg::ST_IDLE && m_valid_reg, "result not issued")

endmodule

`default_nettype wire

@@ sv/gradient_optimizer_update.sv @@
// Top level of the gradient optimizer update block: APB registers plus front/back ends.
// Depends on gou_pkg, gou_front, gou_back.
//
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | operation, element_index, weight, gradient
//  m_      | out       | m_valid / m_ready | result_index, new_weight
//  apb     | in        | psel/penable      | paddr, pwdata, prdata (32-bit data)
//
// Back-end sequencer: an end-of-step word is only popped; SGD and momentum words run
// straight through; RMSprop adds 25 isqrt and 48 divide steps (bit-serial root and divider).
// The front queue (4 words) keeps s_ready high while the back end works, until it fills.
// Reset: synchronous, active low; afterwards a clearing pass zeroes all CACHE_DEPTH (4096)
// step cache entries, with s_ready low; register writes are taken as ever.
// A result waiting on m_ready stalls only the back end; the queue keeps filling.
`default_nettype none

module gradient_optimizer_update (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // input words
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_operation,
    input  wire logic [11:0]        s_element_index,
    input  wire logic signed [31:0] s_weight,
    input  wire logic signed [31:0] s_gradient,
    // result words
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [11:0]             m_result_index,
    output logic signed [31:0]      m_new_weight,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    gou_pkg::cfg_t   cfg_reg;
    gou_pkg::bstat_t bstat;
    gou_pkg::qent_t  q_ent;
    logic            q_valid, q_pop;
    logic            wr_en;
    logic [2:0]      reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // register file; an initial_rate write also reloads the running rate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode       <= gou_pkg::MODE_SGD;
            cfg_reg.init_rate  <= gou_pkg::RATE_RESET;
            cfg_reg.mom_coef   <= gou_pkg::COEF_RESET;
            cfg_reg.sq_decay   <= gou_pkg::COEF_RESET;
            cfg_reg.rate_decay <= gou_pkg::RDEC_RESET;
            cfg_reg.decay_en   <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                gou_pkg::REG_MODE: cfg_reg.mode       <= pwdata[1:0];
                gou_pkg::REG_RATE: cfg_reg.init_rate  <= pwdata[15:0];
                gou_pkg::REG_MOM:  cfg_reg.mom_coef   <= pwdata[15:0];
                gou_pkg::REG_SQD:  cfg_reg.sq_decay   <= pwdata[15:0];
                gou_pkg::REG_RDEC: cfg_reg.rate_decay <= pwdata[15:0];
                gou_pkg::REG_RDEN: cfg_reg.decay_en   <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            gou_pkg::REG_MODE: prdata = 32'(cfg_reg.mode);
            gou_pkg::REG_RATE: prdata = 32'(cfg_reg.init_rate);
            gou_pkg::REG_MOM:  prdata = 32'(cfg_reg.mom_coef);
            gou_pkg::REG_SQD:  prdata = 32'(cfg_reg.sq_decay);
            gou_pkg::REG_RDEC: prdata = 32'(cfg_reg.rate_decay);
            gou_pkg::REG_RDEN: prdata = 32'(cfg_reg.decay_en);
            default:           prdata = '0;
        endcase
    end

    // rate reload strobe is registered: it lands in the cycle after the write, with the new value in place
    logic rate_load_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_load_reg <= 1'b0;
        end else begin
            rate_load_reg <= wr_en && (reg_idx == gou_pkg::REG_RATE);
        end
    end

    gou_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_element_index (s_element_index),
        .s_weight        (s_weight),
        .s_gradient      (s_gradient),
        .mode            (cfg_reg.mode),
        .bstat           (bstat),
        .q_valid         (q_valid),
        .q_ent           (q_ent),
        .q_pop           (q_pop)
    );

    gou_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .rate_load         (rate_load_reg),
        .q_valid           (q_valid),
        .q_ent             (q_ent),
        .q_pop             (q_pop),
        .bstat             (bstat),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_index    (m_result_index),
        .m_new_weight      (m_new_weight)
    );

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for gradient_optimizer_update: APB setup, directed and random words.
// Depends on gou_pkg and the gradient_optimizer_update RTL.
`default_nettype none

module testbench;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_operation = gou_pkg::OP_UPDATE;
    logic [11:0]        s_element_index = '0;
    logic signed [31:0] s_weight = '0;
    logic signed [31:0] s_gradient = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [11:0]        m_result_index;
    logic signed [31:0] m_new_weight;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    gradient_optimizer_update i_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    typedef struct packed {
        logic               op;
        logic [11:0]        idx;
        logic signed [31:0] p;
        logic signed [31:0] g;
    } upd_word_t;

    typedef struct packed {
        logic [11:0]        idx;
        logic signed [31:0] val;
    } param_word_t;

    // predictor state: registers, running rate and per-element cache
    logic [1:0]  mdl_mode;
    logic [15:0] mdl_mom, mdl_sqd, mdl_rdec, mdl_rate;
    logic        mdl_rden;
    logic [31:0] mdl_cache [gou_pkg::CACHE_DEPTH];

    upd_word_t   pending_words[$];
    param_word_t expected_params[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          quiet_tail = 1'b0;   // no idling near the end
    int          hold_off = 0;        // long receiver stall, counted below

    localparam int WATCHDOG = 100000;

    task automatic report(input string what, input longint got, input longint want);
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic longint floor16(input longint x);
        return x >>> 16;   // arithmetic shift floors
    endfunction

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // expected new parameter for one accepted word; updates predictor state
    function automatic void predict_update(input upd_word_t w);
        longint p, g, v, np, rate;
        longint unsigned s, ug, sq, root;
        param_word_t r;
        p = w.p;
        g = w.g;
        rate = longint'(mdl_rate);
        if (w.op == gou_pkg::OP_END) begin
            if (mdl_rden) mdl_rate = 16'((32'(mdl_rate) * 32'(mdl_rdec)) >> 16);
            return;
        end
        if (mdl_mode == gou_pkg::MODE_MOM) begin
            v = longint'(signed'(mdl_cache[w.idx]));
            v = clamp32(floor16(longint'(mdl_mom) * v) + g);
            mdl_cache[w.idx] = v[31:0];
            np = clamp32(p - floor16(rate * v));
        end else if (mdl_mode == gou_pkg::MODE_RMS) begin
            s = mdl_cache[w.idx];
            ug = (g < 0) ? -g : g;
            sq = (ug * ug) >> 16;
            if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;
            s = ((longint'(mdl_sqd) * s) >> 16) + (((65536 - longint'(mdl_sqd)) * sq) >> 16);
            if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
            mdl_cache[w.idx] = s[31:0];
            root = int_sqrt((s + 1) << 16);
            np = clamp32(p - (rate * g) / longint'(root));
        end else begin
            np = clamp32(p - floor16(rate * g));
        end
        r.idx = w.idx;
        r.val = np[31:0];
        expected_params.insert(expected_params.size(), r);
    endfunction

    // driver: words go out at posedge, bursts of idling between them
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (s_valid) predict_update({s_operation, s_element_index,
                                             s_weight, s_gradient});
                if (idle_cycles > 0) begin
                    idle_cycles <= idle_cycles - 1;
                    s_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    upd_word_t w;
                    w = pending_words.pop_front();
                    s_valid <= 1'b1;
                    {s_operation, s_element_index, s_weight, s_gradient} <= w;
                    if (!quiet_tail && $urandom_range(0, 9) == 0)
                        idle_cycles <= $urandom_range(1, 18);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    int rx_idle = 0;
    int rx_count = 0;
    bit stall_done = 1'b0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                rx_count <= rx_count + 1;
                if (expected_params.size() == 0) begin
                    report("unexpected result index", m_result_index, 0);
                end else begin
                    param_word_t e;
                    e = expected_params.pop_front();
                    if (m_result_index !== e.idx) report("result_index", m_result_index, e.idx);
                    if (m_new_weight !== e.val)
                        report("new_weight", m_new_weight, e.val);
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_ready <= 1'b0;
            end else if (!stall_done && rx_count >= 400 && pending_words.size() > 20) begin
                // hold off long enough for the input queue to fill
                hold_off <= 400;
                stall_done <= 1'b1;
                m_ready <= 1'b0;
            end else if (rx_idle > 0) begin
                rx_idle <= rx_idle - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 9) == 0) rx_idle <= $urandom_range(1, 18);
            end
        end
    end

    // watchdog on cycles without any handshake
    int stuck = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || hold_off > 0) stuck <= 0;
        else if (pending_words.size() > 0 || expected_params.size() > 0 || s_valid) begin
            stuck <= stuck + 1;
            if (stuck >= WATCHDOG) begin
                $display("gradient_optimizer_update: mismatch");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [2:0] index, input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(index) << 2; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (index)
            gou_pkg::REG_MODE: mdl_mode = value[1:0];
            gou_pkg::REG_RATE: mdl_rate = value[15:0];
            gou_pkg::REG_MOM:  mdl_mom = value[15:0];
            gou_pkg::REG_SQD:  mdl_sqd = value[15:0];
            gou_pkg::REG_RDEC: mdl_rdec = value[15:0];
            gou_pkg::REG_RDEN: mdl_rden = value[0];
            default: ;
        endcase
    endtask

    // wait until the block has drained; an end-of-step word gives no result
    task automatic drain();
        while (pending_words.size() > 0 || s_valid || expected_params.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom_range(0, 65536 * 4);
            3: return -$signed($urandom_range(0, 65536 * 4));
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_word(input logic op, input logic [11:0] idx,
                                      input logic signed [31:0] p, input logic signed [31:0] g);
        pending_words.insert(pending_words.size(), {op, idx, p, g});
    endfunction

    // one phase of random updates, mostly on a few hot elements so the cache builds up
    function automatic void random_phase(input int count);
        logic [11:0] idx;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                push_word(gou_pkg::OP_END, 12'($urandom), rand_value(), rand_value());
            end else begin
                idx = ($urandom_range(0, 2) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
                push_word(gou_pkg::OP_UPDATE, idx, rand_value(), rand_value());
            end
        end
    endfunction

    initial begin
        mdl_mode = gou_pkg::MODE_SGD;
        mdl_rate = gou_pkg::RATE_RESET;
        mdl_mom = gou_pkg::COEF_RESET;
        mdl_sqd = gou_pkg::COEF_RESET;
        mdl_rdec = gou_pkg::RDEC_RESET;
        mdl_rden = 1'b0;
        for (int i = 0; i < gou_pkg::CACHE_DEPTH; i++) mdl_cache[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, field extremes, both operations
        push_word(gou_pkg::OP_UPDATE, 12'd0, 32'sh7FFF_FFFF, 32'sh8000_0000);
        push_word(gou_pkg::OP_UPDATE, 12'hFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        push_word(gou_pkg::OP_UPDATE, 12'h555, 32'sh0001_0000, 32'sh0000_0000);
        push_word(gou_pkg::OP_END, 12'hAAA, 32'shFFFF_FFFF, 32'sh5555_5555);
        drain();
        // rate decay at the reset factor, then momentum with saturation
        apb_write(gou_pkg::REG_RDEN, 32'd1);
        apb_write(gou_pkg::REG_RATE, 32'hFFFF);
        apb_write(gou_pkg::REG_MODE, 32'(gou_pkg::MODE_MOM));
        push_word(gou_pkg::OP_END, 12'd0, 32'sd0, 32'sd0);
        push_word(gou_pkg::OP_UPDATE, 12'd1, 32'sh7FFF_FFFF, 32'sh8000_0000);
        push_word(gou_pkg::OP_UPDATE, 12'd1, 32'sh8000_0000, 32'sh8000_0000);
        push_word(gou_pkg::OP_UPDATE, 12'd2, 32'sd0, 32'sh7FFF_FFFF);
        push_word(gou_pkg::OP_UPDATE, 12'd2, 32'sd0, 32'sh7FFF_FFFF);
        drain();
        // mode switch: velocity words read as mean squares; zero gradient hits epsilon
        apb_write(gou_pkg::REG_MODE, 32'(gou_pkg::MODE_RMS));
        apb_write(gou_pkg::REG_SQD, 32'd0);
        push_word(gou_pkg::OP_UPDATE, 12'd1, 32'sd0, 32'sh8000_0000);
        push_word(gou_pkg::OP_UPDATE, 12'd3, 32'sd5, 32'sd0);
        push_word(gou_pkg::OP_UPDATE, 12'd2, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        drain();
        apb_write(gou_pkg::REG_MODE, 32'(gou_pkg::MODE_RSVD));   // behaves as plain SGD
        apb_write(gou_pkg::REG_RDEC, 32'd0);
        push_word(gou_pkg::OP_UPDATE, 12'd1, 32'sd100, 32'sh0100_0000);
        push_word(gou_pkg::OP_END, 12'd0, 32'sd0, 32'sd0);
        push_word(gou_pkg::OP_UPDATE, 12'd1, 32'sd100, 32'sh0100_0000);
        drain();

        // random phases over several settings, extremes among them
        for (int ph = 0; ph < 9; ph++) begin
            apb_write(gou_pkg::REG_MODE, 32'(ph % 3));
            apb_write(gou_pkg::REG_RATE,
                      (ph == 3) ? 32'hFFFF : (ph == 4) ? 32'd0 : $urandom_range(0, 65535));
            apb_write(gou_pkg::REG_MOM,
                      (ph == 1) ? 32'hFFFF : (ph == 4) ? 32'd0 : $urandom_range(0, 65535));
            apb_write(gou_pkg::REG_SQD,
                      (ph == 2) ? 32'hFFFF : (ph == 5) ? 32'd0 : $urandom_range(0, 65535));
            apb_write(gou_pkg::REG_RDEC, $urandom_range(60000, 65535));
            apb_write(gou_pkg::REG_RDEN, 32'($urandom_range(0, 1)));
            if (ph == 8) quiet_tail = 1'b1;
            random_phase(150);
            drain();
        end

        if (mismatches == 0) begin
            $display("gradient_optimizer_update: match");
        end else begin
            $display("gradient_optimizer_update: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
